// File: hw/rtl/clex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clex_pkg
// Types, codes and character tables shared by the character literal lexer.
// ----------------------------------------------------------------------------
package clex_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_UTF   = 3'd1,
    PH_TRAIL = 3'd2,
    PH_HEX   = 3'd3,
    PH_NAME  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EOF_CHAR    = 3'd1,
    ST_EOF_HEX     = 3'd2,
    ST_BAD_HEX_END = 3'd3,
    ST_BAD_AFTER_U = 3'd4,
    ST_BAD_SPACE   = 3'd5,
    ST_BAD_NEWLINE = 3'd6,
    ST_BAD_NAME    = 3'd7
  } status_e;

  localparam logic [7:0] CH_U      = 8'h55;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_S_LO   = 8'h73;
  localparam logic [7:0] CH_S_UP   = 8'h53;
  localparam logic [7:0] CH_N_LO   = 8'h6E;
  localparam logic [7:0] CH_N_UP   = 8'h4E;
  localparam logic [31:0] CODE_SPACE   = 32'd32;
  localparam logic [31:0] CODE_NEWLINE = 32'd10;
  localparam logic [2:0] SPACE_LEN   = 3'd4;
  localparam logic [2:0] NEWLINE_LEN = 3'd6;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] code;
    logic [1:0]  bytes_left;
    logic [2:0]  name_pos;
    logic        name_nl;
  } lex_state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] code;
    status_e     status;
    logic        not_consumed;
  } lex_result_t;

  localparam lex_state_t LEX_RESET = '{
    phase:      PH_IDLE,
    code:       32'd0,
    bytes_left: 2'd0,
    name_pos:   3'd0,
    name_nl:    1'b0
  };

  function automatic logic is_alnum(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
           (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
  endfunction

  // letters after the leading s of space
  function automatic logic [7:0] space_tail(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h70;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h63;
      3'd3:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // letters after the leading n of newline
  function automatic logic [7:0] newline_tail(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h65;
      3'd1:    c = 8'h77;
      3'd2:    c = 8'h6C;
      3'd3:    c = 8'h69;
      3'd4:    c = 8'h6E;
      3'd5:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/clex_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clex_step
// Next-state and result logic of the lexer for one byte or end marker.
// ----------------------------------------------------------------------------
module clex_step import clex_pkg::*; (
  input  lex_state_t  st_i,
  input  logic [7:0]  byte_i,
  input  logic        end_i,
  output lex_state_t  st_o,
  output lex_result_t res_o
);

  logic [7:0] low_b;
  logic [7:0] want;
  logic [2:0] len;
  status_e    name_err;
  logic [2:0] pos_inc;
  logic [3:0] hex_nib;
  logic       hex_ok;

  assign low_b    = to_lower(byte_i);
  assign len      = st_i.name_nl ? NEWLINE_LEN : SPACE_LEN;
  assign name_err = st_i.name_nl ? ST_BAD_NEWLINE : ST_BAD_SPACE;
  assign want     = st_i.name_nl ? newline_tail(st_i.name_pos) : space_tail(st_i.name_pos);
  assign pos_inc  = st_i.name_pos + 3'd1;

  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = 4'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      hex_nib = byte_i[3:0];
    end else if ((byte_i >= 8'h61 && byte_i <= 8'h66) ||
                 (byte_i >= 8'h41 && byte_i <= 8'h46)) begin
      hex_nib = byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    st_o  = st_i;
    res_o = '{valid: 1'b0, code: 32'd0, status: ST_OK, not_consumed: 1'b0};
    unique case (st_i.phase)
      PH_UTF: begin
        if (end_i) begin
          res_o = '{valid: 1'b1, code: 32'd0, status: ST_EOF_CHAR, not_consumed: 1'b0};
        end else begin
          st_o.code       = {st_i.code[25:0], byte_i[5:0]};
          st_o.bytes_left = st_i.bytes_left - 2'd1;
          if (st_i.bytes_left == 2'd1) begin
            st_o.phase = PH_TRAIL;
          end
        end
      end
      PH_TRAIL: begin
        if (st_i.code == {24'd0, CH_U}) begin
          if (!end_i && byte_i == CH_LBRACE) begin
            st_o.code  = 32'd0;
            st_o.phase = PH_HEX;
          end else if (end_i || !is_alnum(byte_i)) begin
            res_o = '{valid: 1'b1, code: {24'd0, CH_U}, status: ST_OK,
                      not_consumed: !end_i};
          end else begin
            res_o = '{valid: 1'b1, code: 32'd0, status: ST_BAD_AFTER_U, not_consumed: 1'b0};
          end
        end else if (end_i || !is_alnum(byte_i)) begin
          res_o = '{valid: 1'b1, code: st_i.code, status: ST_OK, not_consumed: !end_i};
        end else if (st_i.code == {24'd0, CH_S_LO} || st_i.code == {24'd0, CH_S_UP}) begin
          if (low_b != space_tail(3'd0)) begin
            res_o = '{valid: 1'b1, code: 32'd0, status: ST_BAD_SPACE, not_consumed: 1'b0};
          end else begin
            st_o.name_nl  = 1'b0;
            st_o.name_pos = 3'd1;
            st_o.phase    = PH_NAME;
          end
        end else if (st_i.code == {24'd0, CH_N_LO} || st_i.code == {24'd0, CH_N_UP}) begin
          if (low_b != newline_tail(3'd0)) begin
            res_o = '{valid: 1'b1, code: 32'd0, status: ST_BAD_NEWLINE, not_consumed: 1'b0};
          end else begin
            st_o.name_nl  = 1'b1;
            st_o.name_pos = 3'd1;
            st_o.phase    = PH_NAME;
          end
        end else begin
          res_o = '{valid: 1'b1, code: 32'd0, status: ST_BAD_NAME, not_consumed: 1'b0};
        end
      end
      PH_HEX: begin
        if (end_i) begin
          res_o = '{valid: 1'b1, code: 32'd0, status: ST_EOF_HEX, not_consumed: 1'b0};
        end else if (hex_ok) begin
          st_o.code = {st_i.code[27:0], hex_nib};
        end else if (byte_i == CH_RBRACE) begin
          res_o = '{valid: 1'b1, code: st_i.code, status: ST_OK, not_consumed: 1'b0};
        end else begin
          res_o = '{valid: 1'b1, code: 32'd0, status: ST_BAD_HEX_END, not_consumed: 1'b0};
        end
      end
      PH_NAME: begin
        if (st_i.name_pos >= len || end_i || low_b != want) begin
          res_o = '{valid: 1'b1, code: 32'd0, status: name_err, not_consumed: 1'b0};
        end else if (pos_inc == len) begin
          res_o = '{valid: 1'b1, code: st_i.name_nl ? CODE_NEWLINE : CODE_SPACE,
                    status: ST_OK, not_consumed: 1'b0};
        end else begin
          st_o.name_pos = pos_inc;
        end
      end
      default: begin
        if (end_i) begin
          res_o = '{valid: 1'b1, code: 32'd0, status: ST_EOF_CHAR, not_consumed: 1'b0};
        end else if (byte_i >= 8'hC0 && byte_i <= 8'hDF) begin
          st_o.code       = {27'd0, byte_i[4:0]};
          st_o.bytes_left = 2'd1;
          st_o.phase      = PH_UTF;
        end else if (byte_i >= 8'hE0 && byte_i <= 8'hEF) begin
          st_o.code       = {28'd0, byte_i[3:0]};
          st_o.bytes_left = 2'd2;
          st_o.phase      = PH_UTF;
        end else if (byte_i >= 8'hF0 && byte_i <= 8'hF7) begin
          st_o.code       = {29'd0, byte_i[2:0]};
          st_o.bytes_left = 2'd3;
          st_o.phase      = PH_UTF;
        end else begin
          st_o.code       = {24'd0, byte_i};
          st_o.bytes_left = 2'd0;
          st_o.phase      = PH_TRAIL;
        end
      end
    endcase
    if (res_o.valid) begin
      st_o = LEX_RESET;
    end
  end

endmodule

// File: hw/rtl/char_literal_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_literal_lexer
// Lexes the body of a character literal, one byte per word: UTF-8 characters,
// U{hex} codes and the names space and newline.
//
//   channel   dir  tdata                 tuser
//   s_axis    in   [7:0] in_byte         [0] at_end
//   m_axis    out  [31:0] char_code      [2:0] status, [3] byte_not_consumed
//
// One word per cycle unless a held result stalls it: each word is first held in
// the input register, then the lexer step updates the state and loads the
// result register.
// Reset clears the lexer state and both valid flags.
// A held result stalls only a word that itself gives a result.
// ----------------------------------------------------------------------------
module char_literal_lexer import clex_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] at_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] char_code
  output logic [3:0]  m_axis_tuser    // [2:0] status, [3] byte_not_consumed
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_end_q;
  lex_state_t  st_q, st_d;
  lex_result_t res_d;
  logic        out_valid_q;
  logic [31:0] out_code_q;
  logic [3:0]  out_user_q;
  logic        out_free;
  logic        step_go;

  clex_step u_step (
    .st_i   (st_q),
    .byte_i (in_byte_q),
    .end_i  (in_end_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_go       = in_valid_q && (!res_d.valid || out_free);
  assign s_axis_tready = !in_valid_q || step_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_end_q  <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= LEX_RESET;
    end else if (step_go) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step_go && res_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step_go && res_d.valid) begin
      out_code_q <= res_d.code;
      out_user_q <= {res_d.not_consumed, res_d.status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_code_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for char_literal_lexer. A short table of literals covers
// every status and the odd inputs; random literals (characters, multi-byte
// UTF-8, U{hex} codes, names and noise) follow. A behavioral lexer predicts
// every result that the table does not give, and each result word is compared
// with the oldest prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
  import clex_pkg::*;

  typedef struct packed {
    logic [31:0] code;
    status_e     status;
    logic        spill;
  } lit_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } word_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eof;
    logic        known;
    logic [31:0] code;
    status_e     status;
    logic        spill;
  } row_t;

  localparam logic [31:0] SPACE_REST   = "pace";
  localparam logic [47:0] NEWLINE_REST = "ewline";

  localparam row_t PLAN [31] = '{
    '{8'h00, 1'b1, 1'b1, 32'd0,  ST_EOF_CHAR,    1'b0},
    '{8'hFF, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h2E, 1'b0, 1'b1, 32'hFF, ST_OK,          1'b1},
    '{8'h78, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h79, 1'b0, 1'b1, 32'd0,  ST_BAD_NAME,    1'b0},
    '{8'h55, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h7B, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h7D, 1'b0, 1'b1, 32'd0,  ST_OK,          1'b0},
    '{8'hC1, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h15, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h39, 1'b0, 1'b1, 32'd0,  ST_BAD_AFTER_U, 1'b0},
    '{8'h55, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h7B, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h7A, 1'b0, 1'b1, 32'd0,  ST_BAD_HEX_END, 1'b0},
    '{8'h55, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h7B, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'hA5, 1'b1, 1'b1, 32'd0,  ST_EOF_HEX,     1'b0},
    '{8'h53, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h71, 1'b0, 1'b1, 32'd0,  ST_BAD_SPACE,   1'b0},
    '{8'h4E, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h78, 1'b0, 1'b1, 32'd0,  ST_BAD_NEWLINE, 1'b0},
    '{8'hF4, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h8F, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'hBF, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'hBF, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h00, 1'b1, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h73, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h50, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h61, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h43, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0},
    '{8'h65, 1'b0, 1'b0, 32'd0,  ST_OK,          1'b0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] in_byte
  logic        s_axis_tuser  = 1'b0;   // [0] at_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [31:0] char_code
  logic [3:0]  m_axis_tuser;           // [2:0] status, [3] byte_not_consumed

  phase_e      lit_phase = PH_IDLE;
  logic [31:0] lit_code  = 32'd0;
  logic [1:0]  utf_left  = 2'd0;
  logic [2:0]  name_pos  = 3'd0;
  logic        name_nl   = 1'b0;

  lit_t        exp_lits [$];
  word_t       pend [$];
  int          bad_count = 0;
  logic        calm      = 1'b0;

  char_literal_lexer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic is_word_char(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic logic [7:0] rest_char(input logic nl, input logic [2:0] pos);
    if (nl) begin
      return NEWLINE_REST[8 * (5 - int'(pos)) +: 8];
    end
    return SPACE_REST[8 * (3 - int'(pos)) +: 8];
  endfunction

  task automatic close_lit(input logic [31:0] code, input status_e st, input logic sp,
                           output logic got, output lit_t r);
    r.code    = code;
    r.status  = st;
    r.spill   = sp;
    got       = 1'b1;
    lit_phase = PH_IDLE;
    lit_code  = 32'd0;
    utf_left  = 2'd0;
    name_pos  = 3'd0;
    name_nl   = 1'b0;
  endtask

  task automatic lex_byte(input logic [7:0] b, input logic eof,
                          output logic got, output lit_t r);
    logic [2:0] len;
    status_e    err;
    got = 1'b0;
    r   = '0;
    case (lit_phase)
      PH_UTF: begin
        if (eof) begin
          close_lit(32'd0, ST_EOF_CHAR, 1'b0, got, r);
        end else begin
          lit_code = {lit_code[25:0], b[5:0]};
          utf_left = utf_left - 2'd1;
          if (utf_left == 2'd0) lit_phase = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        if (lit_code == {24'd0, CH_U}) begin
          if (!eof && b == CH_LBRACE) begin
            lit_code  = 32'd0;
            lit_phase = PH_HEX;
          end else if (eof || !is_word_char(b)) begin
            close_lit({24'd0, CH_U}, ST_OK, !eof, got, r);
          end else begin
            close_lit(32'd0, ST_BAD_AFTER_U, 1'b0, got, r);
          end
        end else if (eof || !is_word_char(b)) begin
          close_lit(lit_code, ST_OK, !eof, got, r);
        end else if (lit_code == {24'd0, CH_S_LO} || lit_code == {24'd0, CH_S_UP}) begin
          if (fold_case(b) != rest_char(1'b0, 3'd0)) begin
            close_lit(32'd0, ST_BAD_SPACE, 1'b0, got, r);
          end else begin
            name_nl   = 1'b0;
            name_pos  = 3'd1;
            lit_phase = PH_NAME;
          end
        end else if (lit_code == {24'd0, CH_N_LO} || lit_code == {24'd0, CH_N_UP}) begin
          if (fold_case(b) != rest_char(1'b1, 3'd0)) begin
            close_lit(32'd0, ST_BAD_NEWLINE, 1'b0, got, r);
          end else begin
            name_nl   = 1'b1;
            name_pos  = 3'd1;
            lit_phase = PH_NAME;
          end
        end else begin
          close_lit(32'd0, ST_BAD_NAME, 1'b0, got, r);
        end
      end
      PH_HEX: begin
        if (eof) begin
          close_lit(32'd0, ST_EOF_HEX, 1'b0, got, r);
        end else if (b >= "0" && b <= "9") begin
          lit_code = {lit_code[27:0], b[3:0]};
        end else if (b >= "a" && b <= "f") begin
          lit_code = {lit_code[27:0], 4'(b - 8'h57)};
        end else if (b >= "A" && b <= "F") begin
          lit_code = {lit_code[27:0], 4'(b - 8'h37)};
        end else if (b == CH_RBRACE) begin
          close_lit(lit_code, ST_OK, 1'b0, got, r);
        end else begin
          close_lit(32'd0, ST_BAD_HEX_END, 1'b0, got, r);
        end
      end
      PH_NAME: begin
        len = name_nl ? NEWLINE_LEN : SPACE_LEN;
        err = name_nl ? ST_BAD_NEWLINE : ST_BAD_SPACE;
        if (name_pos >= len || eof || fold_case(b) != rest_char(name_nl, name_pos)) begin
          close_lit(32'd0, err, 1'b0, got, r);
        end else begin
          name_pos = name_pos + 3'd1;
          if (name_pos == len) begin
            close_lit(name_nl ? CODE_NEWLINE : CODE_SPACE, ST_OK, 1'b0, got, r);
          end
        end
      end
      default: begin
        if (eof) begin
          close_lit(32'd0, ST_EOF_CHAR, 1'b0, got, r);
        end else if (b >= 8'hC0 && b <= 8'hDF) begin
          lit_code  = {27'd0, b[4:0]};
          utf_left  = 2'd1;
          lit_phase = PH_UTF;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          lit_code  = {28'd0, b[3:0]};
          utf_left  = 2'd2;
          lit_phase = PH_UTF;
        end else if (b >= 8'hF0 && b <= 8'hF7) begin
          lit_code  = {29'd0, b[2:0]};
          utf_left  = 2'd3;
          lit_phase = PH_UTF;
        end else begin
          lit_code  = {24'd0, b};
          utf_left  = 2'd0;
          lit_phase = PH_TRAIL;
        end
      end
    endcase
  endtask

  task automatic send_word(input word_t w, input logic known, input lit_t typed);
    logic got;
    lit_t r;
    while (!calm && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w.data;
    s_axis_tuser  <= w.eof;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    lex_byte(w.data, w.eof, got, r);
    if (got) exp_lits.push_back(known ? typed : r);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (exp_lits.size() != 0) @(posedge clk_i);
  endtask

  task automatic queue_word(input logic [7:0] d, input logic eof);
    word_t w;
    w.data = eof ? 8'($urandom_range(255)) : d;
    w.eof  = eof;
    pend.push_back(w);
  endtask

  // end of a character: mostly a delimiter, sometimes end of input or any byte
  task automatic queue_break();
    int         pick;
    logic [7:0] d;
    pick = $urandom_range(99);
    if (pick < 20) begin
      queue_word(8'd0, 1'b1);
    end else if (pick < 80) begin
      do d = 8'($urandom_range(255)); while (is_word_char(d));
      queue_word(d, 1'b0);
    end else begin
      queue_word(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic gen_literal();
    int         kind;
    int         n;
    int         pick;
    logic [7:0] d;
    logic       nl;
    logic [2:0] len;
    logic [2:0] cut;
    kind = $urandom_range(99);
    if (kind < 15) begin
      queue_word(8'($urandom_range(127)), 1'b0);
      queue_break();
    end else if (kind < 32) begin
      n = $urandom_range(1, 3);
      case (n)
        1:       d = 8'hC0 | 8'($urandom_range(31));
        2:       d = 8'hE0 | 8'($urandom_range(15));
        default: d = 8'hF0 | 8'($urandom_range(7));
      endcase
      queue_word(d, 1'b0);
      repeat (n) begin
        if ($urandom_range(99) < 4) begin
          queue_word(8'd0, 1'b1);
          return;
        end
        if ($urandom_range(9) == 0) queue_word(8'($urandom_range(255)), 1'b0);
        else queue_word(8'h80 | 8'($urandom_range(63)), 1'b0);
      end
      queue_break();
    end else if (kind < 52) begin
      // overlong two-byte form of U now and then
      if ($urandom_range(9) == 0) begin
        queue_word(8'hC1, 1'b0);
        queue_word(8'h95, 1'b0);
      end else begin
        queue_word(CH_U, 1'b0);
      end
      queue_word(CH_LBRACE, 1'b0);
      n = ($urandom_range(4) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 8);
      repeat (n) begin
        d = 8'($urandom_range(15));
        if (d < 8'd10) d = d + "0";
        else d = d - 8'd10 + ($urandom_range(1) ? "A" : "a");
        queue_word(d, 1'b0);
      end
      pick = $urandom_range(99);
      if (pick < 85) queue_word(CH_RBRACE, 1'b0);
      else if (pick < 93) queue_word(8'($urandom_range(255)), 1'b0);
      else queue_word(8'd0, 1'b1);
    end else if (kind < 72) begin
      nl  = 1'($urandom_range(1));
      len = nl ? NEWLINE_LEN : SPACE_LEN;
      if (nl) queue_word($urandom_range(1) ? CH_N_UP : CH_N_LO, 1'b0);
      else queue_word($urandom_range(1) ? CH_S_UP : CH_S_LO, 1'b0);
      cut = ($urandom_range(99) < 80) ? len : 3'($urandom_range(0, int'(len) - 1));
      for (int i = 0; i < int'(cut); i++) begin
        d = rest_char(nl, 3'(i));
        if ($urandom_range(1)) d = d - 8'd32;
        queue_word(d, 1'b0);
      end
      if (cut != len) queue_break();
    end else if (kind < 80) begin
      queue_word(CH_U, 1'b0);
      queue_break();
    end else begin
      repeat ($urandom_range(1, 4)) queue_word(8'($urandom_range(255)), $urandom_range(9) == 0);
    end
  endtask

  task automatic flag_bad(input string msg, input lit_t want, input lit_t seen);
    bad_count++;
    if (bad_count <= 10) begin
      $display("%0t: %s: expected code %h status %0d nc %b, got code %h status %0d nc %b",
               $realtime, msg, want.code, want.status, want.spill,
               seen.code, seen.status, seen.spill);
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 19);
  end

  always @(posedge clk_i) begin
    lit_t seen;
    lit_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.code   = m_axis_tdata;
      seen.status = status_e'(m_axis_tuser[2:0]);
      seen.spill  = m_axis_tuser[3];
      if (exp_lits.size() == 0) begin
        flag_bad("unexpected word", '0, seen);
      end else begin
        want = exp_lits.pop_front();
        if (seen.code !== want.code || seen.status !== want.status ||
            seen.spill !== want.spill) begin
          flag_bad("mismatch", want, seen);
        end
      end
    end
  end

  initial begin
    int    rand_sent;
    word_t w;
    lit_t  typed;
    rand_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 31; i++) begin
      w.data       = PLAN[i].data;
      w.eof        = PLAN[i].eof;
      typed.code   = PLAN[i].code;
      typed.status = PLAN[i].status;
      typed.spill  = PLAN[i].spill;
      send_word(w, PLAN[i].known, typed);
    end
    drain();
    while (rand_sent < 400 || pend.size() != 0) begin
      if (pend.size() == 0) gen_literal();
      calm = (rand_sent >= 150 && rand_sent < 250);
      if (rand_sent == 300) drain();
      w = pend.pop_front();
      send_word(w, 1'b0, '0);
      rand_sent++;
    end
    calm = 1'b0;
    drain();
    repeat (10) @(posedge clk_i);
    if (bad_count == 0 && exp_lits.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
